FILE: rtl/cwrpd_pkg.sv
`default_nettype none

package cwrpd_pkg;

    // Fixed field widths
    localparam int CFG_W     = 13;
    localparam int CHAN_W    = 8;
    localparam int TALLY_W   = 5;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 5'd31;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_FRAME_DIM = 4096;
    localparam int DEF_WINDOW_RADIUS = 2;

    // Register reset values
    localparam int WIDTH_RESET  = 1920;
    localparam int HEIGHT_RESET = 1080;

    // Red test thresholds
    localparam logic [CHAN_W-1:0] RED_MIN      = 8'd150;
    localparam logic [CHAN_W-1:0] GREEN_MARGIN = 8'd50;
    localparam logic [CHAN_W-1:0] MAX_MIN      = 8'd80;
    localparam logic [CHAN_W-1:0] SAT_SCALE    = 8'd255;
    localparam logic [CHAN_W-1:0] SAT_LIMIT    = 8'd100;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_start;
    } t_pixel;

    typedef struct packed {
        logic               active;
        logic               changed;
        logic [TALLY_W-1:0] red_pixels;
        logic [TALLY_W-1:0] window_pixels;
    } t_result;

    // Tracker to top: end-of-frame strobe and the frame summary
    typedef struct packed {
        logic    last;
        t_result res;
    } t_track_out;

endpackage

`default_nettype wire

FILE: rtl/center_window_red_pixel_detector.sv
// Center-window red pixel detector.
//
// Input channel (i_valid / o_ready / i_data): one RGB pixel per request, in
// raster order; frame_start marks the first pixel of a frame. The frame size
// comes from the write port (i_cfg_we / i_cfg_idx / i_cfg_data), written
// while the block is idle; 0 reads as 1, larger than MAX_FRAME_DIM as the max.
// Output channel (o_valid / i_ready / o_data): one result per frame, issued
// for the last pixel, with the red and window counts of the center window
// and the active / changed decision.
// Throughput: one pixel per cycle while no result is held up. Each pixel sits in
// the input register while the classifier and window counters work on it; the
// result of a frame's last pixel is then loaded into the output register.
// Stall: a waiting result holds in the output register and blocks the input
// register; one more pixel is taken into an empty input register, then the
// input stage stalls until the pending result leaves.
// Reset: clears position, counts, the previous decision and both valid bits;
// frame width and height return to 1920 x 1080.
`default_nettype none

module center_window_red_pixel_detector
    import cwrpd_pkg::*;
#(
    parameter int MAX_FRAME_DIM = DEF_MAX_FRAME_DIM,
    parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS
)(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire t_pixel      i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output t_result          o_data,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire [CFG_W-1:0]  i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_FRAME_DIM + 1);
    localparam int CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int W_RST = (WIDTH_RESET > MAX_FRAME_DIM) ? MAX_FRAME_DIM : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_FRAME_DIM) ? MAX_FRAME_DIM : HEIGHT_RESET;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [CMP_W-1:0] cfg_ext;
    logic [DIM_W-1:0] cfg_dim;

    t_pixel     r_pix;
    logic       r_pix_vld;
    t_result    r_res;
    logic       r_res_vld;
    logic       out_free;
    logic       adv;
    logic       is_red;
    t_track_out trk;

    // Clamp written dimensions into 1..MAX_FRAME_DIM
    always_comb begin
        cfg_ext = CMP_W'(i_cfg_data);
        if (cfg_ext == '0) begin
            cfg_dim = DIM_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_FRAME_DIM)) begin
            cfg_dim = DIM_W'(MAX_FRAME_DIM);
        end else begin
            cfg_dim = DIM_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(W_RST);
            r_height <= DIM_W'(H_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= cfg_dim;
                CFG_HEIGHT: r_height <= cfg_dim;
                default: ;
            endcase
        end
    end

    // Handshake: the input stage drains whenever the result slot can take it
    assign out_free = !r_res_vld || i_ready;
    assign adv      = r_pix_vld && out_free;
    assign o_ready  = !r_pix_vld || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_vld <= 1'b0;
        end else if (o_ready) begin
            r_pix_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pix <= i_data;
        end
    end

    cwrpd_classify u_classify (
        .i_pix    (r_pix),
        .o_is_red (is_red)
    );

    cwrpd_track #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM),
        .WINDOW_RADIUS (WINDOW_RADIUS)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_frame_start (r_pix.frame_start),
        .i_is_red      (is_red),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_out         (trk)
    );

    // Result register: load on frame end, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (adv && trk.last) begin
            r_res_vld <= 1'b1;
        end else if (i_ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && trk.last) begin
            r_res <= trk.res;
        end
    end

    assign o_valid = r_res_vld;
    assign o_data  = r_res;

endmodule

`default_nettype wire

FILE: rtl/cwrpd_classify.sv
`default_nettype none

module cwrpd_classify
    import cwrpd_pkg::*;
(
    input  wire t_pixel i_pix,
    output logic        o_is_red
);

    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] gb;
    logic [15:0]       sat_lhs;
    logic [15:0]       sat_rhs;
    logic [CHAN_W:0]   g_plus;
    logic              red_max;
    logic              hue_ok;

    // Red must be the largest channel
    assign red_max = (i_pix.red >= i_pix.green) && (i_pix.red >= i_pix.blue);
    assign mn      = (i_pix.green < i_pix.blue) ? i_pix.green : i_pix.blue;
    assign delta   = i_pix.red - mn;
    assign gb      = (i_pix.green > i_pix.blue) ? (i_pix.green - i_pix.blue)
                                                : (i_pix.blue - i_pix.green);

    // Hue within 30 degrees: 2*|g-b| <= max-min
    assign hue_ok  = ({gb, 1'b0} <= {1'b0, delta});

    // Saturation: 255*(max-min) > 100*max
    assign sat_lhs = 16'(delta) * 16'(SAT_SCALE);
    assign sat_rhs = 16'(i_pix.red) * 16'(SAT_LIMIT);

    assign g_plus  = {1'b0, i_pix.green} + {1'b0, GREEN_MARGIN};

    assign o_is_red = red_max && hue_ok && (sat_lhs > sat_rhs) &&
                      (i_pix.red > MAX_MIN) && (i_pix.red > RED_MIN) &&
                      ({1'b0, i_pix.red} > g_plus);

endmodule

`default_nettype wire

FILE: rtl/cwrpd_track.sv
`default_nettype none

module cwrpd_track
    import cwrpd_pkg::*;
#(
    parameter int MAX_FRAME_DIM = DEF_MAX_FRAME_DIM,
    parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS,
    localparam int DIM_W = $clog2(MAX_FRAME_DIM + 1)
)(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_adv,
    input  wire              i_frame_start,
    input  wire              i_is_red,
    input  wire [DIM_W-1:0]  i_width,
    input  wire [DIM_W-1:0]  i_height,
    output t_track_out       o_out
);

    localparam int CNT_W = $clog2(MAX_FRAME_DIM);
    localparam int NW    = DIM_W + 1;

    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [TALLY_W-1:0] r_red, n_red;
    logic [TALLY_W-1:0] r_samp, n_samp;
    logic               r_prev, n_prev;

    logic [CNT_W-1:0]   cur_col;
    logic [CNT_W-1:0]   cur_row;
    logic [TALLY_W-1:0] cur_red;
    logic [TALLY_W-1:0] cur_samp;
    logic [NW-1:0]      col_x;
    logic [NW-1:0]      row_x;
    logic [NW-1:0]      cx;
    logic [NW-1:0]      cy;
    logic [NW-1:0]      rad;
    logic               in_win;
    logic               line_end;
    logic               frame_end;
    logic [TALLY_W-1:0] fin_red;
    logic [TALLY_W-1:0] fin_samp;
    logic               active;

    // Frame start clears position and tallies ahead of this pixel
    assign cur_col  = i_frame_start ? '0 : r_col;
    assign cur_row  = i_frame_start ? '0 : r_row;
    assign cur_red  = i_frame_start ? '0 : r_red;
    assign cur_samp = i_frame_start ? '0 : r_samp;

    assign col_x = NW'(cur_col);
    assign row_x = NW'(cur_row);
    assign cx    = NW'(i_width >> 1);
    assign cy    = NW'(i_height >> 1);
    assign rad   = NW'(WINDOW_RADIUS);

    // Window test, clipped to the frame
    assign in_win = (col_x < NW'(i_width)) && (row_x < NW'(i_height)) &&
                    (col_x + rad >= cx) && (col_x <= cx + rad) &&
                    (row_x + rad >= cy) && (row_x <= cy + rad);

    // Saturating tallies
    always_comb begin
        fin_samp = cur_samp;
        fin_red  = cur_red;
        if (in_win) begin
            if (cur_samp < TALLY_MAX) fin_samp = cur_samp + 1'b1;
            if (i_is_red && (cur_red < TALLY_MAX)) fin_red = cur_red + 1'b1;
        end
    end

    assign line_end  = !(col_x + 1'b1 < NW'(i_width));
    assign frame_end = line_end && !(row_x + 1'b1 < NW'(i_height));
    assign active    = (8'(fin_red) * 8'd5) > (8'(fin_samp) * 8'd2);

    // Advance position, close the frame on its last pixel
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_red  = r_red;
        n_samp = r_samp;
        n_prev = r_prev;
        if (i_adv) begin
            n_red  = fin_red;
            n_samp = fin_samp;
            n_row  = cur_row;
            if (!line_end) begin
                n_col = cur_col + 1'b1;
            end else begin
                n_col = '0;
                if (!frame_end) begin
                    n_row = cur_row + 1'b1;
                end else begin
                    n_row  = '0;
                    n_red  = '0;
                    n_samp = '0;
                    n_prev = active;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_red  <= '0;
            r_samp <= '0;
            r_prev <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_red  <= n_red;
            r_samp <= n_samp;
            r_prev <= n_prev;
        end
    end

    assign o_out.last              = frame_end;
    assign o_out.res.active        = active;
    assign o_out.res.changed       = active ^ r_prev;
    assign o_out.res.red_pixels    = fin_red;
    assign o_out.res.window_pixels = fin_samp;

endmodule

`default_nettype wire

FILE: rtl/cwrpd_checker.sv
`default_nettype none

module cwrpd_checker
    import cwrpd_pkg::*;
(
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          o_valid,
    input wire          i_ready,
    input wire t_result o_data
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // Red count never exceeds the window count
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.red_pixels <= o_data.window_pixels)
        else $error("red count above window count");

    // Decision matches the counts
    a_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.active ==
            ((8'(o_data.red_pixels) * 8'd5) > (8'(o_data.window_pixels) * 8'd2)))
        else $error("active disagrees with counts");

    // Reset empties the result slot
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind center_window_red_pixel_detector cwrpd_checker u_cwrpd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire

FILE: tb/center_window_red_pixel_detector_test.sv
`timescale 1ns / 100ps

module center_window_red_pixel_detector_test;
    import cwrpd_pkg::*;

    localparam int STALL_LIMIT    = 3000;
    localparam int RANDOM_PIXELS  = 780;
    localparam int RANDOM_FRAMES  = 15;
    localparam int PIPE_SETTLE    = 4;
    localparam int HOLD_OFF_LEN   = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       px_valid = 1'b0;
    logic       px_ready;
    t_pixel     px_data = '0;
    logic       sum_valid;
    logic       sum_ready = 1'b0;
    t_result    sum_data;
    logic       cfg_we = 1'b0;
    t_cfg_idx   cfg_idx = CFG_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    // predicted block state
    logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RESET);
    logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RESET);
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned red_count = 0;
    int unsigned window_count = 0;
    bit          last_active = 1'b0;
    t_result     pending_summaries[$];

    int err_count = 0;
    int pixels_sent = 0;
    int summaries_predicted = 0;
    int src_gap_max = 0;
    int rcv_gap_max = 0;
    int hold_off_len = 0;
    int idle_cycles = 0;

    center_window_red_pixel_detector dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (px_valid),
        .o_ready    (px_ready),
        .i_data     (px_data),
        .o_valid    (sum_valid),
        .i_ready    (sum_ready),
        .o_data     (sum_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int unsigned clip_dim(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEF_MAX_FRAME_DIM) return DEF_MAX_FRAME_DIM;
        return int'(v);
    endfunction

    function automatic bit is_red_pixel(int unsigned r, int unsigned g, int unsigned b);
        int unsigned lo;
        int unsigned spread;
        int unsigned hue_diff;
        if (r < g || r < b) return 1'b0;
        lo = (g < b) ? g : b;
        spread = r - lo;
        hue_diff = (g > b) ? g - b : b - g;
        if (2 * hue_diff > spread) return 1'b0;
        if (int'(SAT_SCALE) * spread <= int'(SAT_LIMIT) * r) return 1'b0;
        if (r <= int'(MAX_MIN)) return 1'b0;
        if (r <= int'(RED_MIN)) return 1'b0;
        if (r <= g + int'(GREEN_MARGIN)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit near_center(int unsigned pos, int unsigned center);
        return pos + DEF_WINDOW_RADIUS >= center && pos <= center + DEF_WINDOW_RADIUS;
    endfunction

    // Advance the frame position for one accepted pixel; queue a summary on frame end
    function automatic void tally_pixel(t_pixel px);
        int unsigned w;
        int unsigned h;
        t_result sum;
        w = clip_dim(width_reg);
        h = clip_dim(height_reg);
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
            red_count = 0;
            window_count = 0;
        end
        if (col_pos < w && row_pos < h && near_center(col_pos, w / 2) &&
            near_center(row_pos, h / 2)) begin
            if (window_count < TALLY_MAX) window_count++;
            if (is_red_pixel(px.red, px.green, px.blue) && red_count < TALLY_MAX)
                red_count++;
        end
        if (col_pos + 1 < w) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < h) begin
            row_pos++;
            return;
        end
        sum.active = (red_count * 5 > window_count * 2);
        sum.changed = (sum.active != last_active);
        sum.red_pixels = red_count[TALLY_W-1:0];
        sum.window_pixels = window_count[TALLY_W-1:0];
        pending_summaries.push_back(sum);
        summaries_predicted++;
        last_active = sum.active;
        row_pos = 0;
        red_count = 0;
        window_count = 0;
    endfunction

    // Red-biased pixel source: surely red, near the thresholds, or anything
    function automatic t_pixel make_pixel(int red_pct, bit start);
        t_pixel px;
        int unsigned r;
        int pick;
        pick = $urandom_range(0, 99);
        px = t_pixel'($urandom);
        if (pick < red_pct) begin
            r = $urandom_range(151, 255);
            px.red = CHAN_W'(r);
            px.green = CHAN_W'($urandom_range(0, r / 3));
            px.blue = CHAN_W'($urandom_range(0, r / 3));
        end else if (pick[0]) begin
            r = $urandom_range(100, 255);
            px.red = CHAN_W'(r);
            px.green = CHAN_W'($urandom_range(0, r));
            px.blue = CHAN_W'($urandom_range(0, r));
        end
        px.frame_start = start;
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 200)
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        err_count++;
    endtask

    // Offer one pixel after a random gap and hold it until accepted
    task automatic send_pixel(input t_pixel px);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            px_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        px_valid <= 1'b1;
        px_data <= px;
        do @(posedge clk); while (!px_ready);
        tally_pixel(px);
        pixels_sent++;
    endtask

    // Drop valid, drain all summaries, then let the pipeline empty
    task automatic settle();
        px_valid <= 1'b0;
        while (pending_summaries.size() != 0) @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_WIDTH)
            width_reg = value[CFG_W-1:0];
        else
            height_reg = value[CFG_W-1:0];
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        settle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // One frame's worth of pixels; noisy frames may skip or repeat frame_start
    task automatic send_frame(input bit noisy);
        int unsigned n;
        int red_pct;
        bit start;
        n = clip_dim(width_reg) * clip_dim(height_reg);
        red_pct = $urandom_range(0, 100);
        for (int unsigned i = 0; i < n; i++) begin
            if (i == 0)
                start = !noisy || ($urandom_range(0, 99) < 85);
            else
                start = noisy && ($urandom_range(0, 199) == 0);
            send_pixel(make_pixel(red_pct, start));
        end
    endtask

    // A few pixels at the reset frame size: no summary, then restarted later
    task automatic test_reset_defaults();
        src_gap_max = 3;
        rcv_gap_max = 3;
        repeat (6) send_pixel(make_pixel(50, 1'b0));
    endtask

    // Single-pixel frames: every pixel yields a summary with its own class
    task automatic test_pixel_classes();
        logic [3*CHAN_W-1:0] colors [16];
        colors = '{24'hFF0000, 24'h970000, 24'h960000, 24'h510000,
                   24'hFFFFFF, 24'h000000, 24'hFF9696, 24'hFF9B9B,
                   24'hFF007F, 24'hFF0080, 24'hFF7F00, 24'hFF8000,
                   24'h64C832, 24'hC8C800, 24'hFFCD9B, 24'h32C8FF};
        set_frame(1, 1);
        for (int i = 0; i < 16; i++)
            send_pixel(t_pixel'({colors[i], 1'b1}));
    endtask

    // Out-of-range sizes: clipped frames, closed early by a smaller rewrite
    task automatic test_frame_limits();
        src_gap_max = 1;
        rcv_gap_max = 12;
        // 8191 x 0 reads as one line of 4096 pixels
        set_frame(8191, 0);
        for (int i = 0; i < 40; i++) send_pixel(make_pixel(60, i == 0));
        settle();
        write_reg(CFG_WIDTH, 0);
        send_pixel(make_pixel(60, 1'b0));
        // 0 x 8191 reads as one column of 4096 lines
        set_frame(0, 8191);
        for (int i = 0; i < 40; i++) send_pixel(make_pixel(60, i == 0));
        settle();
        write_reg(CFG_HEIGHT, 1);
        send_pixel(make_pixel(60, 1'b0));
    endtask

    // Registers rewritten in the middle of a frame
    task automatic test_mid_frame_config();
        src_gap_max = 4;
        rcv_gap_max = 4;
        // move the window after it was passed: both tallies saturate
        set_frame(5, 10);
        for (int i = 0; i < 40; i++) send_pixel(make_pixel(100, i == 0));
        settle();
        write_reg(CFG_HEIGHT, 30);
        for (int i = 0; i < 110; i++) send_pixel(make_pixel(100, 1'b0));
        // column already beyond the new width
        set_frame(20, 4);
        for (int i = 0; i < 13; i++) send_pixel(make_pixel(60, i == 0));
        settle();
        write_reg(CFG_WIDTH, 6);
        for (int i = 0; i < 30; i++) send_pixel(make_pixel(60, 1'b0));
        // row already beyond the new height
        set_frame(4, 10);
        for (int i = 0; i < 30; i++) send_pixel(make_pixel(60, i == 0));
        settle();
        write_reg(CFG_HEIGHT, 3);
        for (int i = 0; i < 8; i++) send_pixel(make_pixel(60, 1'b0));
    endtask

    // Receiver holds off while the sender keeps offering single-pixel frames
    task automatic test_output_stall();
        set_frame(1, 1);
        src_gap_max = 0;
        hold_off_len = HOLD_OFF_LEN;
        for (int i = 0; i < 40; i++) send_pixel(make_pixel(50, 1'b1));
    endtask

    // Random sizes and pacing per phase, mostly small frames
    task automatic test_random_frames();
        int first_pixel;
        int first_summary;
        int pick;
        int unsigned w;
        int unsigned h;
        first_pixel = pixels_sent;
        first_summary = summaries_predicted;
        while (pixels_sent - first_pixel < RANDOM_PIXELS ||
               summaries_predicted - first_summary < RANDOM_FRAMES) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                w = $urandom_range(0, 8);
                h = $urandom_range(0, 8);
            end else begin
                w = $urandom_range(1, 40);
                h = $urandom_range(1, 10);
            end
            set_frame(w, h);
            src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            rcv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            repeat ($urandom_range(1, 4)) send_frame(1'b1);
        end
    endtask

    // Check each accepted summary and pace the output ready
    initial begin
        t_result want;
        bit took;
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            took = sum_valid && sum_ready;
            if (took) begin
                if (pending_summaries.size() == 0) begin
                    report_mismatch("summary with none expected", sum_data, 0);
                end else begin
                    want = pending_summaries.pop_front();
                    if (sum_data.active !== want.active)
                        report_mismatch("active", sum_data.active, want.active);
                    if (sum_data.changed !== want.changed)
                        report_mismatch("changed", sum_data.changed, want.changed);
                    if (sum_data.red_pixels !== want.red_pixels)
                        report_mismatch("red_pixels", sum_data.red_pixels,
                                        want.red_pixels);
                    if (sum_data.window_pixels !== want.window_pixels)
                        report_mismatch("window_pixels", sum_data.window_pixels,
                                        want.window_pixels);
                end
            end
            if (hold_off_len > 0) begin
                stall_left = hold_off_len;
                hold_off_len = 0;
            end else if (took) begin
                stall_left = $urandom_range(0, rcv_gap_max);
            end
            if (stall_left > 0) begin
                sum_ready <= 1'b0;
                stall_left--;
            end else begin
                sum_ready <= 1'b1;
            end
        end
    end

    // End the run when no request moves for too long
    always @(posedge clk) begin
        if (!rst_n || (px_valid && px_ready) || (sum_valid && sum_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("center_window_red_pixel_detector_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_pixel_classes();
        test_mid_frame_config();
        test_output_stall();
        test_frame_limits();
        test_random_frames();
        settle();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("center_window_red_pixel_detector_test: done, clean");
        else
            $display("center_window_red_pixel_detector_test: done, errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/cwrpd_pkg.sv
rtl/cwrpd_classify.sv
rtl/cwrpd_track.sv
rtl/center_window_red_pixel_detector.sv
rtl/cwrpd_checker.sv
tb/center_window_red_pixel_detector_test.sv
